// ===== src/swm_pkg.sv =====
// Shared widths, command and status bundles for the sliding window median block.
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RESULT_W = 33;
    localparam int SIZE_W   = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_wr;      // take a new window size and empty the window
        logic start;       // latch the incoming word, apply restart
        logic ring_rd;     // read the oldest ring entry
        logic old_load;    // latch the oldest value
        logic rm_init;     // index to zero for the removal scan
        logic rm_rd;       // read sorted[idx]
        logic rm_next;     // idx + 1
        logic sh_rd;       // read sorted[idx + 1]
        logic sh_wr;       // sorted[idx] = read data, idx + 1
        logic fill_dec;    // one copy removed
        logic ins_init;    // idx = fill
        logic ins_rd;      // read sorted[idx - 1]
        logic ins_shift;   // sorted[idx] = read data, idx - 1
        logic ins_place;   // sorted[idx] = new sample
        logic finish;      // ring write, pointer and fill update
        logic med_rd_hi;   // read sorted[k / 2]
        logic med_rd_lo;   // latch upper middle, read sorted[(k - 1) / 2]
        logic out_load;    // load the result register
    } swm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // fill equals window size
        logic idx_at_fill; // removal scan reached the end
        logic match;       // read data equals the oldest value
        logic shift_more;  // idx + 1 below fill
        logic idx_zero;    // insertion reached the bottom
        logic greater;     // read data above the new sample
        logic fill_max;    // sorted store has no room
        logic will_full;   // window is full after this insertion
        logic out_busy;    // result register holds an untaken word
    } swm_status_t;

endpackage

// ===== src/swm_datapath.sv =====
// Datapath: sorted store, arrival ring, counters and result register.
module swm_datapath
    import swm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  swm_cmd_t                   cmd,
    output swm_status_t                status,
    input  logic [SIZE_W-1:0]          cfg_window_size,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RESULT_W-1:0] m_median_doubled
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int RESET_SIZE = (WINDOW_DEPTH < 3) ? WINDOW_DEPTH : 3;

    logic signed [SAMPLE_W-1:0] sorted_mem [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] ring_mem   [WINDOW_DEPTH];

    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic signed [SAMPLE_W-1:0] ring_data_reg;
    logic                       m_valid_reg, m_valid_next;
    logic signed [RESULT_W-1:0] m_data_reg;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic [CW:0]                slot_diff;
    logic [AW-1:0]              old_slot;
    logic [CW-1:0]              size_eff;

    // Oldest slot: pointer minus window size, modulo the depth.
    always_comb begin
        slot_diff = (CW+1)'(ptr_reg) - (CW+1)'(k_reg);
        if (slot_diff[CW]) begin
            old_slot = AW'(slot_diff + (CW+1)'(WINDOW_DEPTH));
        end else begin
            old_slot = AW'(slot_diff);
        end
    end

    always_comb begin
        if (cfg_window_size == '0) begin
            size_eff = CW'(1);
        end else if (32'(cfg_window_size) > WINDOW_DEPTH) begin
            size_eff = CW'(WINDOW_DEPTH);
        end else begin
            size_eff = CW'(cfg_window_size);
        end
    end

    // Sorted store port selection.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(idx_reg);
        wr_en   = 1'b0;
        wr_addr = AW'(idx_reg);
        wr_data = v_reg;
        if (cmd.rm_rd) begin
            rd_en = 1'b1;
        end
        if (cmd.sh_rd) begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_reg + CW'(1));
        end
        if (cmd.ins_rd) begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_reg - CW'(1));
        end
        if (cmd.med_rd_hi) begin
            rd_en   = 1'b1;
            rd_addr = AW'(k_reg >> 1);
        end
        if (cmd.med_rd_lo) begin
            rd_en   = 1'b1;
            rd_addr = AW'((k_reg - CW'(1)) >> 1);
        end
        if (cmd.sh_wr || cmd.ins_shift) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end
        if (cmd.ins_place) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sorted_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= sorted_mem[rd_addr];
        end
        if (cmd.finish) begin
            ring_mem[ptr_reg] <= v_reg;
        end
        if (cmd.ring_rd) begin
            ring_data_reg <= ring_mem[old_slot];
        end
    end

    always_comb begin
        k_next       = k_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (cmd.cfg_wr) begin
            k_next    = size_eff;
            fill_next = '0;
            ptr_next  = '0;
        end
        if (cmd.start && (s_restart || fill_reg > k_reg)) begin
            fill_next = '0;
            ptr_next  = '0;
        end
        if (cmd.rm_init) begin
            idx_next = '0;
        end
        if (cmd.rm_next || cmd.sh_wr) begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.fill_dec) begin
            fill_next = fill_reg - CW'(1);
        end
        if (cmd.ins_init) begin
            idx_next = fill_reg;
        end
        if (cmd.ins_shift) begin
            idx_next = idx_reg - CW'(1);
        end
        if (cmd.finish) begin
            if (!status.fill_max) begin
                fill_next = fill_reg + CW'(1);
            end
            if (ptr_reg == AW'(WINDOW_DEPTH - 1)) begin
                ptr_next = '0;
            end else begin
                ptr_next = ptr_reg + AW'(1);
            end
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= CW'(RESET_SIZE);
            fill_reg    <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg <= idx_next;
        if (cmd.start) begin
            v_reg <= s_sample;
        end
        if (cmd.old_load) begin
            old_reg <= ring_data_reg;
        end
        if (cmd.med_rd_lo) begin
            hi_reg <= rd_data_reg;
        end
        if (cmd.out_load) begin
            m_data_reg <= RESULT_W'(hi_reg) + RESULT_W'(rd_data_reg);
        end
    end

    always_comb begin
        status.full        = (fill_reg == k_reg);
        status.idx_at_fill = (idx_reg == fill_reg);
        status.match       = (rd_data_reg == old_reg);
        status.shift_more  = ((CW+1)'(idx_reg) + (CW+1)'(1)) < (CW+1)'(fill_reg);
        status.idx_zero    = (idx_reg == '0);
        status.greater     = (rd_data_reg > v_reg);
        status.fill_max    = (fill_reg == CW'(WINDOW_DEPTH));
        status.will_full   = ((CW+1)'(fill_reg) + (CW+1)'(status.fill_max ? 0 : 1))
                             == (CW+1)'(k_reg);
        status.out_busy    = m_valid_reg && !m_ready;
    end

    assign m_valid          = m_valid_reg;
    assign m_median_doubled = m_data_reg;

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= k_reg)
        else $error("fill count above window size");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < WINDOW_DEPTH)
        else $error("ring pointer out of range");

    a_no_dual_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins_place && (cmd.ins_shift || cmd.sh_wr)))
        else $error("two writes to the sorted store");

endmodule

// ===== src/swm_ctrl.sv =====
// Controller: sequences removal, insertion and median read per input word.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_RING_WAIT, ST_RM_RD, ST_RM_CMP, ST_SH_RD, ST_SH_WR,
        ST_INS_INIT, ST_INS_RD, ST_INS_CMP, ST_FIN, ST_MED_A, ST_MED_B, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_wr = 1'b1;
                end else if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.full) begin
                    cmd.ring_rd = 1'b1;
                    state_next  = ST_RING_WAIT;
                end else begin
                    cmd.ins_init = 1'b1;
                    state_next   = ST_INS_RD;
                end
            end
            ST_RING_WAIT: begin
                cmd.old_load = 1'b1;
                cmd.rm_init  = 1'b1;
                state_next   = ST_RM_RD;
            end
            ST_RM_RD: begin
                if (status.idx_at_fill) begin
                    state_next = ST_INS_INIT;
                end else begin
                    cmd.rm_rd  = 1'b1;
                    state_next = ST_RM_CMP;
                end
            end
            ST_RM_CMP: begin
                if (status.match) begin
                    state_next = ST_SH_RD;
                end else begin
                    cmd.rm_next = 1'b1;
                    state_next  = ST_RM_RD;
                end
            end
            ST_SH_RD: begin
                if (status.shift_more) begin
                    cmd.sh_rd  = 1'b1;
                    state_next = ST_SH_WR;
                end else begin
                    cmd.fill_dec = 1'b1;
                    state_next   = ST_INS_INIT;
                end
            end
            ST_SH_WR: begin
                cmd.sh_wr  = 1'b1;
                state_next = ST_SH_RD;
            end
            ST_INS_INIT: begin
                cmd.ins_init = 1'b1;
                state_next   = ST_INS_RD;
            end
            ST_INS_RD: begin
                if (status.fill_max) begin
                    state_next = ST_FIN;
                end else if (status.idx_zero) begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (status.greater) begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_RD;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = status.will_full ? ST_MED_A : ST_IDLE;
            end
            ST_MED_A: begin
                cmd.med_rd_hi = 1'b1;
                state_next    = ST_MED_B;
            end
            ST_MED_B: begin
                cmd.med_rd_lo = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;

endmodule

// ===== src/sliding_window_median.sv =====
// Top level of the sliding window median filter.
//
// The input channel (s_valid, s_ready, s_sample, s_restart) takes one signed
// 32-bit word at a time. The block keeps the last window_size samples in an
// arrival ring and in a sorted store, both single-port memories. Once the
// window is full, each word yields one result on the output channel
// (m_valid, m_ready, m_median_doubled): twice the window median, a signed
// value with one fraction bit. Before that, words produce no result.
// The configuration channel (cfg_valid, cfg_ready, cfg_window_size) sets the
// window size; zero acts as one, values above WINDOW_DEPTH saturate, and a
// write empties the window. A set s_restart also empties it first.
// Words are processed one at a time by a controller walking the sorted
// store entry by entry; a new word is accepted only once the controller is
// back in idle. The removal scan and the insertion shift through the one
// sorted store port set how long a word takes.
// A result sits in an output register; the next word is accepted while it
// waits, and the controller only holds if a new result is ready before the
// receiver takes the old one. Reset empties the window and sets the size to 3.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [SIZE_W-1:0]          cfg_window_size,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RESULT_W-1:0] m_median_doubled
);

    swm_cmd_t    cmd;
    swm_status_t status;

    // Controller: one state machine stepping through each word's work.
    swm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: the two memories, counters and the result register.
    swm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_window_size  (cfg_window_size),
        .s_sample         (s_sample),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_doubled (m_median_doubled)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for the sliding window median filter with a self-checking median predictor.
`timescale 1ns / 1ps

module tb_top
    import swm_pkg::*;
();

    localparam int DEPTH     = 64;
    localparam int PERIOD    = 12;
    // Settle for longer than the slowest word takes.
    localparam int SETTLE    = 4 * DEPTH + 60;
    localparam int LONG_HOLD = 600;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } word_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [SIZE_W-1:0]          cfg_window_size;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_restart;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [RESULT_W-1:0] m_median_doubled;

    sliding_window_median #(.WINDOW_DEPTH(DEPTH)) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_window_size  (cfg_window_size),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_doubled (m_median_doubled)
    );

    // Words waiting to be sent and medians waiting to come back.
    word_t                      send_words[$];
    logic signed [RESULT_W-1:0] median_queue[$];
    int                         error_count = 0;
    int                         medians_taken = 0;

    // Predictor state: the window in sorted and in arrival order.
    logic signed [SAMPLE_W-1:0] pred_sorted[DEPTH];
    logic signed [SAMPLE_W-1:0] pred_ring[DEPTH];
    int                         pred_ptr;
    int                         pred_fill;
    int                         pred_size;

    initial begin
        aclk = 1'b0;
        forever #(PERIOD / 2) aclk = ~aclk;
    end

    // Zero acts as one and anything above the depth saturates.
    function automatic int effective_size();
        int k;
        k = pred_size;
        if (k == 0) begin
            k = 1;
        end
        if (k > DEPTH) begin
            k = DEPTH;
        end
        return k;
    endfunction

    // Advances the predicted window by one word and yields the median if the window is full.
    task automatic update_window(input word_t w, output bit produced,
                                 output logic signed [RESULT_W-1:0] med);
        int k;
        int pos;
        int i;
        int j;
        logic signed [SAMPLE_W-1:0] oldest;
        k = effective_size();
        produced = 1'b0;
        med = '0;
        if (w.restart || pred_fill > k) begin
            pred_ptr = 0;
            pred_fill = 0;
        end
        // A full window drops its oldest sample; with duplicates only one copy goes.
        if (pred_fill == k) begin
            oldest = pred_ring[(pred_ptr + DEPTH - k) % DEPTH];
            for (i = 0; i < pred_fill; i++) begin
                if (pred_sorted[i] == oldest) begin
                    for (j = i; j + 1 < pred_fill; j++) begin
                        pred_sorted[j] = pred_sorted[j + 1];
                    end
                    pred_fill--;
                    break;
                end
            end
        end
        if (pred_fill < DEPTH) begin
            pos = pred_fill;
            while (pos > 0 && pred_sorted[pos - 1] > w.sample) begin
                pred_sorted[pos] = pred_sorted[pos - 1];
                pos--;
            end
            pred_sorted[pos] = w.sample;
            pred_fill++;
        end
        pred_ring[pred_ptr] = w.sample;
        pred_ptr = (pred_ptr + 1) % DEPTH;
        if (pred_fill == k) begin
            produced = 1'b1;
            med = RESULT_W'(pred_sorted[k / 2]) + RESULT_W'(pred_sorted[(k - 1) / 2]);
        end
    endtask

    // The sender runs in bursts of random length separated by random gaps.
    // All bookkeeping happens at the edge where the word is taken, using
    // the values that were on the ports just before that edge.
    int    burst_left = 0;
    int    gap_left = 0;
    word_t held_word;

    always @(posedge aclk) begin
        bit                         produced;
        logic signed [RESULT_W-1:0] med;
        bit                         busy;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_sample  <= '0;
            s_restart <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                update_window(held_word, produced, med);
                if (produced) begin
                    median_queue.insert(median_queue.size(), med);
                end
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (send_words.size() > 0) begin
                    held_word = send_words.pop_front();
                    s_valid   <= 1'b1;
                    s_sample  <= held_word.sample;
                    s_restart <= held_word.restart;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Start a new burst after a gap; some bursts are long with no gaps.
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 8);
                        gap_left = $urandom_range(0, 5);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls on its own pattern. Once, after a few dozen medians,
    // it holds off for a long stretch so the result register fills and the
    // block has to back up onto its input.
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  stall_phase = 0;

    always @(posedge aclk) begin
        logic signed [RESULT_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                medians_taken++;
                if (median_queue.size() == 0) begin
                    $display("%0t: unexpected median, expected none, actual %0d",
                             $realtime, m_median_doubled);
                    error_count++;
                end else begin
                    want = median_queue.pop_front();
                    if (m_median_doubled !== want) begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $realtime, want, m_median_doubled);
                        error_count++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 400;
            if (!long_hold_done && medians_taken >= 40) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_phase < 150) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= $urandom_range(0, 2) != 0;
            end
        end
    end

    // Waits until the sender is empty and every median has arrived, then lets
    // the block finish any word that produces no median.
    task automatic wait_drained();
        while (send_words.size() > 0 || s_valid || median_queue.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes the window size; only called while the block is idle.
    task automatic write_size(input logic [SIZE_W-1:0] size_val);
        @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_window_size <= size_val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        pred_size = size_val;
        pred_ptr  = 0;
        pred_fill = 0;
    endtask

    task automatic queue_word(input logic signed [SAMPLE_W-1:0] v, input logic rs);
        word_t w;
        w.sample  = v;
        w.restart = rs;
        send_words.insert(send_words.size(), w);
    endtask

    // Mostly full-range samples; a narrow range brings plenty of duplicates.
    task automatic queue_random(input int count, input bit narrow);
        int n;
        logic signed [SAMPLE_W-1:0] v;
        for (n = 0; n < count; n++) begin
            if (narrow || $urandom_range(0, 3) == 0) begin
                v = $signed($urandom_range(0, 6)) - 3;
            end else begin
                v = $urandom;
            end
            queue_word(v, $urandom_range(0, 29) == 0);
        end
    endtask

    initial begin
        int n;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_window_size = '0;
        pred_size       = 3;
        pred_ptr        = 0;
        pred_fill       = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset size of three: extremes, duplicates and restarts.
        queue_word(32'sh7FFFFFFF, 1'b0);
        queue_word(32'sh80000000, 1'b0);
        queue_word(32'sh7FFFFFFF, 1'b0);
        queue_word(32'sh7FFFFFFF, 1'b0);
        queue_word(32'sh80000000, 1'b0);
        queue_word(32'sh80000000, 1'b0);
        queue_word(32'sh80000000, 1'b0);
        queue_word(0, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(5, 1'b1);
        queue_word(5, 1'b0);
        queue_word(5, 1'b0);
        queue_word(2, 1'b0);
        queue_word(9, 1'b0);
        queue_word(5, 1'b0);
        queue_word(32'sh55555555, 1'b1);
        queue_word(32'shAAAAAAAA, 1'b0);
        queue_word(1, 1'b0);
        queue_word(-7, 1'b0);
        queue_random(150, 1'b0);
        // Let the pipeline run dry once in the middle of the stream.
        while (send_words.size() > 30) begin
            @(posedge aclk);
        end
        wait_drained();
        queue_random(30, 1'b0);
        wait_drained();

        // Zero behaves as a window of one.
        write_size(7'd0);
        queue_random(70, 1'b0);
        wait_drained();

        write_size(7'd2);
        queue_random(100, 1'b0);
        wait_drained();

        // The full depth, with occasional random restarts.
        write_size(7'd64);
        queue_random(100, 1'b0);
        wait_drained();

        // Above the depth saturates to the depth.
        write_size(7'd127);
        for (n = 0; n < 70; n++) begin
            queue_word($urandom, 1'b0);
        end
        wait_drained();

        write_size(7'd5);
        queue_random(80, 1'b1);
        wait_drained();

        write_size(SIZE_W'($urandom_range(1, 64)));
        queue_random(80, 1'b0);
        wait_drained();

        write_size(7'd1);
        queue_random(40, 1'b0);
        wait_drained();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sliding_window_median.f =====
src/swm_pkg.sv
src/swm_datapath.sv
src/swm_ctrl.sv
src/sliding_window_median.sv
test/tb_top.sv
